[rtl/bdh_pkg.sv]
// Shared types and constants for the button debounce and hold block.
package bdh_pkg;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned DEB_W   = 8;
  localparam int unsigned SUS_W   = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 2;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd20;
  localparam logic [SUS_W-1:0] SUSTAIN_RST  = 16'd1000;

  typedef enum logic [IDX_W-1:0] {
    REG_INVERT    = 2'd0,
    REG_DEBOUNCE  = 2'd1,
    REG_SUSTAIN   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_RELEASED  = 2'd0,
    PH_PRESSED   = 2'd1,
    PH_SUSTAINED = 2'd2
  } phase_t;

  typedef struct packed {
    logic                invert_level;
    logic [DEB_W-1:0]    debounce_ms;
    logic [SUS_W-1:0]    sustain_ms;
  } cfg_t;

  typedef struct packed {
    logic                last_level;
    logic [STAMP_W-1:0]  change_stamp;
    logic                pending;
    phase_t              phase;
  } state_t;

  typedef struct packed {
    logic   press;
    logic   release_ev;
    logic   hold;
    logic   change;
    phase_t phase;
  } result_t;

endpackage

[rtl/button_debounce_hold.sv]
// Top level: push-button debouncer with hold repeat, state and output buffering.
//
// Each input beat is one poll of a button pin: in_raw_level and a wrapping
// millisecond timestamp in_now_ms. Each accepted poll yields exactly one
// output beat carrying press, release, hold and change flags plus the
// button phase after that poll (0 released, 1 pressed, 2 sustained).
// A beat moves when valid is high and stall is low on its channel.
//
// One subtract and a few compares run in the cycle the poll is accepted, and
// the result is registered into the output or skid register. The block takes
// one poll per cycle while in_stall is low, updating its state on each poll.
//
// A two-entry output buffer (output register plus skid register) lets a
// poll be taken while a result waits. in_stall rises only once both hold
// a result; beats are never dropped or reordered.
//
// Synchronous reset (rst_n low) clears the buffers and returns the state to
// released, level high, nothing pending, and the registers to their
// defaults (active-low wiring, 20 ms debounce, 1000 ms sustain).
// Configuration writes of zero to either interval are ignored.
module button_debounce_hold import bdh_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  // poll channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_raw_level,
  input  logic [STAMP_W-1:0]  in_now_ms,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_press_event,
  output logic                out_release_event,
  output logic                out_hold_event,
  output logic                out_change_event,
  output logic [1:0]          out_button_phase
);

  cfg_t    cfg_r, cfg_nxt;
  state_t  st_r, st_nxt;
  result_t res;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  logic    in_fire;
  logic    out_fire;

  // Register file; zero intervals are rejected.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_INVERT: cfg_nxt.invert_level = cfg_wdata[0];
        REG_DEBOUNCE: begin
          if (cfg_wdata[DEB_W-1:0] != '0) cfg_nxt.debounce_ms = cfg_wdata[DEB_W-1:0];
        end
        REG_SUSTAIN: begin
          if (cfg_wdata[SUS_W-1:0] != '0) cfg_nxt.sustain_ms = cfg_wdata[SUS_W-1:0];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  bdh_update u_update (
    .cfg       (cfg_r),
    .cur       (st_r),
    .raw_level (in_raw_level),
    .now_ms    (in_now_ms),
    .nxt       (st_nxt),
    .res       (res)
  );

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = main_valid_r && !out_stall;

  // Output buffer: refill the output register from skid first, else from
  // the new poll; park the new poll in skid while the output is held.
  always_comb begin
    main_nxt       = main_r;
    main_valid_nxt = main_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_fire || !main_valid_r) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = res;
        main_valid_nxt = in_fire;
      end
    end else if (in_fire) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert_level <= 1'b0;
      cfg_r.debounce_ms  <= DEBOUNCE_RST;
      cfg_r.sustain_ms   <= SUSTAIN_RST;
      st_r.last_level    <= 1'b1;
      st_r.change_stamp  <= '0;
      st_r.pending       <= 1'b0;
      st_r.phase         <= PH_RELEASED;
      main_valid_r       <= 1'b0;
      skid_valid_r       <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      // advance the poll state only on an accepted beat
      if (in_fire) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = main_valid_r;
  assign out_press_event   = main_r.press;
  assign out_release_event = main_r.release_ev;
  assign out_hold_event    = main_r.hold;
  assign out_change_event  = main_r.change;
  assign out_button_phase  = main_r.phase;

  // Skid entry only fills behind a held output register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid holds a beat while the output register is empty");

  // A change flag goes with exactly one of press or release.
  a_change_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_change_event == (out_press_event ^ out_release_event)) &&
                  !(out_press_event && out_release_event))
    else $error("change flag inconsistent with press/release");

  // A release never carries a hold and leaves the phase released.
  a_release_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_release_event) |->
      (!out_hold_event && out_button_phase == PH_RELEASED))
    else $error("release beat with hold or wrong phase");

  // A result that is stalled must hold across the next edge.
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(main_r)))
    else $error("stalled result changed");

endmodule

[rtl/bdh_update.sv]
// Per-poll state update: level compare, elapsed-time checks and event decode.
module bdh_update import bdh_pkg::*; (
  input  cfg_t                cfg,
  input  state_t              cur,
  input  logic                raw_level,
  input  logic [STAMP_W-1:0]  now_ms,
  output state_t              nxt,
  output result_t             res
);

  logic               level;
  logic               changed;
  logic [STAMP_W-1:0] elapsed;
  logic               hold;
  logic               dispatch;
  phase_t             ph;

  always_comb begin
    level    = raw_level ^ cfg.invert_level;
    changed  = (level != cur.last_level);
    elapsed  = now_ms - cur.change_stamp;
    hold     = !changed && (cur.phase != PH_RELEASED) &&
               (elapsed >= STAMP_W'(cfg.sustain_ms));
    // A level change or a hold restarts the timer, and debounce_ms is never
    // zero, so the debounce test can only pass on an untouched timer.
    dispatch = !changed && !hold && cur.pending &&
               (elapsed >= STAMP_W'(cfg.debounce_ms));

    ph = hold ? PH_SUSTAINED : cur.phase;
    if (dispatch) begin
      ph = level ? PH_RELEASED : PH_PRESSED;
    end

    nxt.last_level   = level;
    nxt.change_stamp = (changed || hold) ? now_ms : cur.change_stamp;
    nxt.pending      = changed ? 1'b1 : (dispatch ? 1'b0 : cur.pending);
    nxt.phase        = ph;

    res.press      = dispatch && !level;
    res.release_ev = dispatch && level;
    res.hold       = hold;
    res.change     = dispatch;
    res.phase      = ph;
  end

endmodule

[tb/sv/bdh_poll_checker.sv]
// Checker for the button debounce block: tracks config, predicts each poll result, compares.
`timescale 1ns / 100ps

module bdh_poll_checker import bdh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_raw_level,
  input  logic [STAMP_W-1:0] in_now_ms,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_press_event,
  input  logic               out_release_event,
  input  logic               out_hold_event,
  input  logic               out_change_event,
  input  logic [1:0]         out_button_phase,
  output int                 fail_count,
  output int                 waiting
);

  cfg_t    timing;
  state_t  btn;
  result_t expected_polls[$];
  result_t want;
  result_t got;

  // Advance the button state by one poll and return the flags it raises.
  task automatic debounce_poll(input logic raw, input logic [STAMP_W-1:0] t,
                               output result_t r);
    logic               lvl;
    logic [STAMP_W-1:0] elapsed;
    r   = '0;
    lvl = raw ^ timing.invert_level;
    if (lvl != btn.last_level) begin
      btn.change_stamp = t;
      btn.pending      = 1'b1;
    end else if (btn.phase == PH_PRESSED || btn.phase == PH_SUSTAINED) begin
      elapsed = t - btn.change_stamp;
      if (elapsed >= timing.sustain_ms) begin
        r.hold           = 1'b1;
        btn.phase        = PH_SUSTAINED;
        btn.change_stamp = t;
      end
    end
    elapsed = t - btn.change_stamp;
    if (elapsed >= timing.debounce_ms && btn.pending) begin
      if (lvl == 1'b0) begin
        r.press   = 1'b1;
        btn.phase = PH_PRESSED;
      end else begin
        r.release_ev = 1'b1;
        r.hold       = 1'b0;
        btn.phase    = PH_RELEASED;
      end
      r.change    = 1'b1;
      btn.pending = 1'b0;
    end
    btn.last_level = lvl;
    r.phase        = btn.phase;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      timing.invert_level = 1'b0;
      timing.debounce_ms  = DEBOUNCE_RST;
      timing.sustain_ms   = SUSTAIN_RST;
      btn.last_level      = 1'b1;
      btn.change_stamp    = '0;
      btn.pending         = 1'b0;
      btn.phase           = PH_RELEASED;
      expected_polls.delete();
    end else begin
      // a result cannot leave in the cycle its poll is accepted, so retire before predicting
      if (out_valid && !out_stall) begin
        got.press      = out_press_event;
        got.release_ev = out_release_event;
        got.hold       = out_hold_event;
        got.change     = out_change_event;
        got.phase      = phase_t'(out_button_phase);
        if (expected_polls.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result beat with no poll waiting", $realtime);
          fail_count++;
        end else begin
          want = expected_polls.pop_front();
          if (got.press !== want.press || got.release_ev !== want.release_ev ||
              got.hold !== want.hold || got.change !== want.change ||
              got.phase !== want.phase) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp press=%0b rel=%0b hold=%0b chg=%0b ph=%0d",
                       $realtime, want.press, want.release_ev, want.hold, want.change,
                       want.phase, " got press=%0b rel=%0b hold=%0b chg=%0b ph=%0d",
                       got.press, got.release_ev, got.hold, got.change, got.phase);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_INVERT: timing.invert_level = cfg_wdata[0];
          REG_DEBOUNCE: begin
            if (cfg_wdata[DEB_W-1:0] != '0) timing.debounce_ms = cfg_wdata[DEB_W-1:0];
          end
          REG_SUSTAIN: begin
            if (cfg_wdata[SUS_W-1:0] != '0) timing.sustain_ms = cfg_wdata[SUS_W-1:0];
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        debounce_poll(in_raw_level, in_now_ms, want);
        expected_polls.push_back(want);
      end
    end
    waiting = expected_polls.size();
  end

endmodule

[tb/sv/tb_button_debounce_hold.sv]
// Testbench top for the button debounce block: clock, reset, poll and config stimulus, verdict.
`timescale 1ns / 100ps

module tb_button_debounce_hold import bdh_pkg::*; ();

  // index with no register behind it; writes there must do nothing
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_raw_level = 1'b1;
  logic [STAMP_W-1:0] in_now_ms = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_press_event;
  logic               out_release_event;
  logic               out_hold_event;
  logic               out_change_event;
  logic [1:0]         out_button_phase;

  int fail_count;
  int waiting;

  // pacing knobs, in percent of cycles
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  // shadow of the effective timing, used only to shape poll levels and time steps
  logic               pressed_lvl = 1'b0;
  int unsigned        deb_now = 20;
  int unsigned        sus_now = 1000;
  logic [STAMP_W-1:0] clock_ms = '0;
  int unsigned        polls_sent = 0;
  int unsigned        seg_start;

  logic in_fire = 1'b0;

  always #5 clk = ~clk;

  button_debounce_hold u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_raw_level      (in_raw_level),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_press_event   (out_press_event),
    .out_release_event (out_release_event),
    .out_hold_event    (out_hold_event),
    .out_change_event  (out_change_event),
    .out_button_phase  (out_button_phase)
  );

  bdh_poll_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_raw_level      (in_raw_level),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_press_event   (out_press_event),
    .out_release_event (out_release_event),
    .out_hold_event    (out_hold_event),
    .out_change_event  (out_change_event),
    .out_button_phase  (out_button_phase),
    .fail_count        (fail_count),
    .waiting           (waiting)
  );

  // Latch the poll handshake as seen at the edge; the driver reads it at the next fall.
  always @(posedge clk) begin
    in_fire <= in_valid && !in_stall;
  end

  // Receiver back-pressure: one fresh decision per cycle.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Offer one poll beat and hold it until it is taken. Entered and left on a falling edge.
  task automatic send_poll(input logic lvl, input logic [STAMP_W-1:0] t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_raw_level <= lvl;
    in_now_ms    <= t;
    do @(negedge clk); while (!in_fire);
    polls_sent++;
  endtask

  // Drop valid and wait until every poll has its result, then idle for a short margin.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Program all three registers and remember the values for step shaping.
  task automatic set_timing(input logic pd, input int unsigned deb, input int unsigned sus);
    write_reg(REG_INVERT, {15'd0, pd});
    write_reg(REG_DEBOUNCE, CFG_W'(deb));
    write_reg(REG_SUSTAIN, CFG_W'(sus));
    pressed_lvl = pd;
    deb_now     = deb;
    sus_now     = sus;
  endtask

  // Time step mix: mostly around the debounce window, some near the sustain
  // interval, and now and then a wild jump that may run backwards.
  function automatic logic [STAMP_W-1:0] pick_step();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 5) return STAMP_W'($urandom_range(deb_now + 3));
    if (k < 8) return STAMP_W'($urandom_range(sus_now / 2 + 1));
    if (k < 9) return STAMP_W'($urandom_range(sus_now + 1, sus_now - 1));
    return $urandom();
  endfunction

  // One press: bounce in, hold a while, bounce out, rest released.
  task automatic press_cycle();
    int unsigned n;
    n = $urandom_range(4);
    repeat (n) begin
      clock_ms += $urandom_range(deb_now / 2);
      send_poll(1'($urandom_range(1)), clock_ms);
    end
    n = $urandom_range(8, 1);
    repeat (n) begin
      clock_ms += pick_step();
      send_poll(pressed_lvl, clock_ms);
    end
    n = $urandom_range(3);
    repeat (n) begin
      clock_ms += $urandom_range(deb_now / 2);
      send_poll(1'($urandom_range(1)), clock_ms);
    end
    n = $urandom_range(4, 1);
    repeat (n) begin
      clock_ms += pick_step();
      send_poll(~pressed_lvl, clock_ms);
    end
  endtask

  task automatic noise_poll();
    if ($urandom_range(7) == 0) clock_ms = $urandom();
    else clock_ms += pick_step();
    send_poll(1'($urandom_range(1)), clock_ms);
  endtask

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero intervals and the unused index must leave the defaults in place.
    write_reg(REG_DEBOUNCE, 16'h0000);
    write_reg(REG_SUSTAIN, 16'h0000);
    write_reg(REG_UNUSED, 16'hFFFF);

    // Default timing: 20 ms debounce, 1000 ms sustain, active-low wiring.
    send_poll(1'b1, 32'd0);            // idle, nothing changes
    send_poll(1'b0, 32'd5);            // edge, timer restarts
    send_poll(1'b0, 32'd24);           // one short of debounce
    send_poll(1'b0, 32'd25);           // press
    send_poll(1'b0, 32'd1025);         // first hold
    send_poll(1'b1, 32'd1030);         // bounce up
    send_poll(1'b0, 32'd1031);         // bounce down, still pending
    send_poll(1'b0, 32'd3000);         // hold restarts timer, debounce sees zero
    send_poll(1'b0, 32'd3020);         // pending press lands
    send_poll(1'b1, 32'd3025);         // start of release
    send_poll(1'b1, 32'd2);            // backwards stamp reads as huge: hold, no release
    send_poll(1'b1, 32'd22);           // release
    send_poll(1'b0, 32'hFFFF_FFF0);    // edge just before wrap
    send_poll(1'b0, 32'h0000_0004);    // press across the wrap
    send_poll(1'b1, 32'hFFFF_FFFF);    // edge, going backwards
    send_poll(1'b1, 32'hFFFF_FFFF);    // same stamp, zero elapsed

    // Pull-down wiring at the shortest intervals.
    drain();
    set_timing(1'b1, 1, 1);
    send_poll(1'b0, 32'd100);          // reads as released, no change
    send_poll(1'b1, 32'd100);          // edge toward pressed
    send_poll(1'b1, 32'd101);          // hold, press still pending
    send_poll(1'b1, 32'd102);          // hold
    send_poll(1'b0, 32'd102);          // edge toward released
    send_poll(1'b0, 32'd103);          // hold, release still pending

    // Upper bits only: bit 0 clear drops the inversion, a zero low byte is ignored.
    drain();
    write_reg(REG_INVERT, 16'hFFFE);
    write_reg(REG_DEBOUNCE, 16'h0100);
    write_reg(REG_SUSTAIN, 16'hFFFF);
    pressed_lvl = 1'b0;
    sus_now     = 65535;
    send_poll(1'b0, 32'd200);
    send_poll(1'b0, 32'd201);
    send_poll(1'b1, 32'd66000);
    send_poll(1'b1, 32'd66001);

    // Random part: six segments cycling through the pacing modes, each with
    // its own timing; the first two use the extremes.
    for (int seg = 0; seg < 6; seg++) begin
      drain();
      idle_pct  = 0;
      stall_pct = 0;
      if (seg == 0) set_timing(1'b0, 1, 1);
      else if (seg == 1) set_timing(1'b1, 255, 65535);
      else begin
        write_reg(REG_DEBOUNCE, {8'($urandom_range(255)), 8'h00});
        write_reg(REG_UNUSED, 16'($urandom()));
        set_timing(1'($urandom_range(1)),
                   ($urandom_range(3) == 0) ? $urandom_range(255, 1) : $urandom_range(40, 1),
                   ($urandom_range(3) == 0) ? $urandom_range(65535, 1) : $urandom_range(400, 1));
      end
      case (seg % 4)
        1: idle_pct = 87;
        2: stall_pct = 87;
        3: begin
          idle_pct  = 33;
          stall_pct = 33;
        end
        default: ;
      endcase
      clock_ms  = $urandom();
      seg_start = polls_sent;
      while (polls_sent - seg_start < 150) begin
        if ($urandom_range(9) < 8) press_cycle();
        else repeat (3) noise_poll();
      end
    end

    // Wait out the tail, then give the verdict.
    drain();
    if (fail_count == 0 && waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
